// File: hdl/tnt_pkg.sv
package tnt_pkg;

  localparam int MANT_BITS = 30;
  localparam int ROOT_BITS = MANT_BITS + 1;
  localparam int SUM_BITS  = 2 * MANT_BITS + 2;
  localparam int OUT_WIDTH = 16;

  typedef struct packed {
    logic vld;
    logic ok;
  } ctl_t;

endpackage

// File: hdl/tnt_isqrt.sv
module tnt_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  tnt_pkg::ctl_t                    in_ctl,
  input  logic [tnt_pkg::SUM_BITS-1:0]     in_rad,
  input  logic [SIDE_W-1:0]                in_side,
  output tnt_pkg::ctl_t                    out_ctl,
  output logic [tnt_pkg::ROOT_BITS-1:0]    out_root,
  output logic [SIDE_W-1:0]                out_side
);

  localparam int RB = tnt_pkg::ROOT_BITS;
  localparam int SB = tnt_pkg::SUM_BITS;
  localparam int CW = SB + 2;

  tnt_pkg::ctl_t   ctl  [0:RB];
  logic [SB-1:0]   rem  [0:RB];
  logic [RB-1:0]   root [0:RB];
  logic [SIDE_W-1:0] side [0:RB];

  assign ctl[0]  = in_ctl;
  assign rem[0]  = in_rad;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < RB; k++) begin : g_step
    localparam int BIT = RB - 1 - k;
    logic [CW-1:0] cand;
    logic          take;

    always_comb begin
      cand = ((CW'(root[k]) << 1) + (CW'(1) << BIT)) << BIT;
      take = ({2'b00, rem[k]} >= cand);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].vld <= 1'b0;
      end else if (en) begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? SB'(CW'(rem[k]) - cand) : rem[k];
        root[k+1] <= take ? (root[k] | (RB'(1) << BIT)) : root[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_ctl  = ctl[RB];
  assign out_root = root[RB];
  assign out_side = side[RB];

endmodule

// File: hdl/tnt_div.sv
module tnt_div #(
  parameter int FRAC   = 14,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  tnt_pkg::ctl_t                    in_ctl,
  input  logic [tnt_pkg::MANT_BITS-1:0]    in_mant,
  input  logic [tnt_pkg::ROOT_BITS-1:0]    in_len,
  input  logic [SIDE_W-1:0]                in_side,
  output tnt_pkg::ctl_t                    out_ctl,
  output logic [FRAC:0]                    out_quot,
  output logic [SIDE_W-1:0]                out_side
);

  localparam int RB = tnt_pkg::ROOT_BITS;
  localparam int QB = FRAC + 1;
  localparam int DW = RB + FRAC + 1;

  tnt_pkg::ctl_t     ctl  [0:QB];
  logic [DW-1:0]     rem  [0:QB];
  logic [RB-1:0]     len  [0:QB];
  logic [QB-1:0]     quot [0:QB];
  logic [SIDE_W-1:0] side [0:QB];

  assign ctl[0]  = in_ctl;
  assign rem[0]  = (DW'(in_mant) << FRAC) + DW'(in_len >> 1);
  assign len[0]  = in_len;
  assign quot[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int BIT = QB - 1 - k;
    logic [DW-1:0] dvs;
    logic          take;

    always_comb begin
      dvs  = DW'(len[k]) << BIT;
      take = (rem[k] >= dvs);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].vld <= 1'b0;
      end else if (en) begin
        ctl[k+1] <= ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? (rem[k] - dvs) : rem[k];
        len[k+1]  <= len[k];
        quot[k+1] <= take ? (quot[k] | (QB'(1) << BIT)) : quot[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_ctl  = ctl[QB];
  assign out_quot = quot[QB];
  assign out_side = side[QB];

endmodule

// File: hdl/tnt_unit.sv
module tnt_unit #(
  parameter int VW   = 68,
  parameter int FRAC = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  tnt_pkg::ctl_t                        in_ctl,
  input  logic signed [VW-1:0]                 in_vec  [3],
  output tnt_pkg::ctl_t                        out_ctl,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] out_vec [3]
);

  localparam int MB = tnt_pkg::MANT_BITS;
  localparam int RB = tnt_pkg::ROOT_BITS;
  localparam int SB = tnt_pkg::SUM_BITS;
  localparam int OW = tnt_pkg::OUT_WIDTH;
  localparam int TW = $clog2(VW + 1);
  localparam int QB = FRAC + 1;
  localparam int SIDE_W = 3 * MB + 3;

  tnt_pkg::ctl_t c1, c2, c3, c4;
  logic [VW-1:0]   mag  [3];
  logic [2:0]      neg1, neg2, neg3, neg4;
  logic [TW-1:0]   top;
  logic [MB-1:0]   m2   [3];
  logic [MB-1:0]   m3   [3];
  logic [MB-1:0]   m4   [3];
  logic [2*MB-1:0] sq   [3];
  logic [SB-1:0]   sum;

  logic [VW-1:0]   orv;
  logic [TW-1:0]   top_next;

  tnt_pkg::ctl_t   rctl;
  logic [RB-1:0]   root;
  logic [SIDE_W-1:0] rside;

  tnt_pkg::ctl_t   dctl  [3];
  logic [QB-1:0]   quot  [3];
  logic            dneg  [3];

  always_comb begin
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      orv = orv | (in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]));
    end
    top_next = '0;
    for (int b = 0; b < VW; b++) begin
      if (orv[b]) begin
        top_next = TW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
      c2.vld <= 1'b0;
      c3.vld <= 1'b0;
      c4.vld <= 1'b0;
    end else if (en) begin
      c1 <= in_ctl;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_vec[i][VW-1];
        mag[i]  <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
        m2[i]   <= MB'(({mag[i], {MB{1'b0}}}) >> top);
        m3[i]   <= m2[i];
        sq[i]   <= m2[i] * m2[i];
        m4[i]   <= m3[i];
      end
      top  <= top_next;
      neg2 <= neg1;
      neg3 <= neg2;
      neg4 <= neg3;
      sum  <= SB'(sq[0]) + SB'(sq[1]) + SB'(sq[2]);
    end
  end

  tnt_isqrt #(
    .SIDE_W(SIDE_W)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (c4),
    .in_rad  (sum),
    .in_side ({m4[0], m4[1], m4[2], neg4}),
    .out_ctl (rctl),
    .out_root(root),
    .out_side(rside)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    tnt_div #(
      .FRAC  (FRAC),
      .SIDE_W(1)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_ctl  (rctl),
      .in_mant (rside[3 + (2 - i) * MB +: MB]),
      .in_len  (root),
      .in_side (rside[i]),
      .out_ctl (dctl[i]),
      .out_quot(quot[i]),
      .out_side(dneg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.vld <= 1'b0;
    end else if (en) begin
      out_ctl <= dctl[0];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [QB-1:0]      qc;
    logic signed [QB:0] sv;

    always_comb begin
      qc = (quot[i] > (QB'(1) << FRAC)) ? (QB'(1) << FRAC) : quot[i];
      sv = dneg[i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        out_vec[i] <= dctl[0].ok ? OW'(sv) : '0;
      end
    end
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (dctl[0].vld == dctl[1].vld) && (dctl[0].vld == dctl[2].vld))
    else $error("divider lanes out of step");

endmodule

// File: hdl/triangle_normal_tangent_core.sv
// Channel   Signals                                    Direction
// in        in_valid, in_ready, ax ay az bx by bz cx cy cz   into the core
// out       out_valid, out_ready, normal_x/y/z, tangent_x/y/z,
//           normal_ok, tangent_ok                      out of the core
//
// One transaction may enter every cycle unless out stalls; the path is 3 front
// stages, 4 scaling stages, 31 square root stages, UNIT_FRAC_BITS + 1 divider
// stages and one output register. The square root pipeline sets depth.
// Reset clears all valid bits; no transaction is in flight afterward.
// A stall on out freezes the whole pipeline, and in_ready drops with it.
module triangle_normal_tangent_core #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        ax,
  input  logic signed [COORD_WIDTH-1:0]        ay,
  input  logic signed [COORD_WIDTH-1:0]        az,
  input  logic signed [COORD_WIDTH-1:0]        bx,
  input  logic signed [COORD_WIDTH-1:0]        by,
  input  logic signed [COORD_WIDTH-1:0]        bz,
  input  logic signed [COORD_WIDTH-1:0]        cx,
  input  logic signed [COORD_WIDTH-1:0]        cy,
  input  logic signed [COORD_WIDTH-1:0]        cz,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] normal_x,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] normal_y,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] normal_z,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] tangent_x,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] tangent_y,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] tangent_z,
  output logic                                 normal_ok,
  output logic                                 tangent_ok
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;
  localparam int VW = XW + 1;
  localparam int OW = tnt_pkg::OUT_WIDTH;

  logic en;
  logic v1, v2, v3;

  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PW-1:0] pa, pb, pc, pd, pe, pf;
  logic signed [XW-1:0] n0, n1, n2;

  tnt_pkg::ctl_t        nctl_in, tctl_in, nctl, tctl;
  logic signed [VW-1:0] nvec [3];
  logic signed [VW-1:0] tvec [3];
  logic signed [OW-1:0] nout [3];
  logic signed [OW-1:0] tout [3];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= EW'(bx) - EW'(ax);
      e1y <= EW'(by) - EW'(ay);
      e1z <= EW'(bz) - EW'(az);
      e2x <= EW'(cx) - EW'(ax);
      e2y <= EW'(cy) - EW'(ay);
      e2z <= EW'(cz) - EW'(az);
      pa  <= e1y * e2z;
      pb  <= e1z * e2y;
      pc  <= e1z * e2x;
      pd  <= e1x * e2z;
      pe  <= e1x * e2y;
      pf  <= e1y * e2x;
      n0  <= XW'(pa) - XW'(pb);
      n1  <= XW'(pc) - XW'(pd);
      n2  <= XW'(pe) - XW'(pf);
    end
  end

  // With u = x and v = y the tangent reduces to (|det|, 0, -sign(det) * nx).
  always_comb begin
    nvec[0] = VW'(n0);
    nvec[1] = VW'(n1);
    nvec[2] = VW'(n2);
    tvec[0] = n2[XW-1] ? -VW'(n2) : VW'(n2);
    tvec[1] = '0;
    tvec[2] = n2[XW-1] ? VW'(n0) : -VW'(n0);
    nctl_in.vld = v3;
    nctl_in.ok  = (n0 != '0) || (n1 != '0) || (n2 != '0);
    tctl_in.vld = v3;
    tctl_in.ok  = (n2 != '0);
  end

  tnt_unit #(
    .VW  (VW),
    .FRAC(UNIT_FRAC_BITS)
  ) u_normal (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (nctl_in),
    .in_vec (nvec),
    .out_ctl(nctl),
    .out_vec(nout)
  );

  tnt_unit #(
    .VW  (VW),
    .FRAC(UNIT_FRAC_BITS)
  ) u_tangent (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (tctl_in),
    .in_vec (tvec),
    .out_ctl(tctl),
    .out_vec(tout)
  );

  assign out_valid  = nctl.vld;
  assign normal_ok  = nctl.ok;
  assign tangent_ok = tctl.ok;
  assign normal_x   = nout[0];
  assign normal_y   = nout[1];
  assign normal_z   = nout[2];
  assign tangent_x  = tout[0];
  assign tangent_y  = tout[1];
  assign tangent_z  = tout[2];

  a_units_aligned: assert property (@(posedge clk) disable iff (rst)
    nctl.vld == tctl.vld)
    else $error("normal and tangent pipelines out of step");

  a_normal_zeroed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !normal_ok |-> (normal_x == '0) && (normal_y == '0) && (normal_z == '0))
    else $error("degenerate normal not zeroed");

  a_tangent_zeroed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tangent_ok |-> (tangent_x == '0) && (tangent_y == '0) && (tangent_z == '0))
    else $error("degenerate tangent not zeroed");

  a_tangent_needs_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && tangent_ok |-> normal_ok)
    else $error("tangent valid on a degenerate triangle");

endmodule
